@@ rtl/rbd_pkg.sv @@
// Package for the ring buffer deque: action and status codes, control word
// fields and the microcode program. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    // Action codes of a request.
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [2:0] ACT_PEEK_BACK  = 3'd5;
    localparam logic [2:0] ACT_INSERT     = 3'd6;

    // Status codes of a result.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Step address of the sequencer.
    typedef logic [3:0] t_step;

    localparam t_step STEP_IDLE     = 4'd0;
    localparam t_step STEP_PUSHF    = 4'd1;
    localparam t_step STEP_PUSHB    = 4'd2;
    localparam t_step STEP_POPF_RD  = 4'd3;
    localparam t_step STEP_POPF_EM  = 4'd4;
    localparam t_step STEP_POPB_RD  = 4'd5;
    localparam t_step STEP_POPB_EM  = 4'd6;
    localparam t_step STEP_PEEKF_RD = 4'd7;
    localparam t_step STEP_PEEKB_RD = 4'd8;
    localparam t_step STEP_PEEK_EM  = 4'd9;
    localparam t_step STEP_INS_CHK  = 4'd10;
    localparam t_step STEP_INS_LOOP = 4'd11;
    localparam t_step STEP_INS_MOVE = 4'd12;
    localparam t_step STEP_INS_PUT  = 4'd13;
    localparam t_step STEP_NOP      = 4'd14;

    // Precondition checked by a step; a failing check ends the request.
    typedef enum logic [1:0] {CHK_NONE, CHK_FULL, CHK_EMPTY, CHK_INSERT} t_chk;
    // Next-step selection.
    typedef enum logic [1:0] {JMP_NEXT, JMP_IDLE, JMP_TARGET, JMP_IF_DONE} t_jmp;
    // Memory operation.
    typedef enum logic [1:0] {MEM_NONE, MEM_READ, MEM_WRITE} t_mem;
    // Memory address source.
    typedef enum logic [2:0] {
        ADR_FRONT, ADR_FRONT_DEC, ADR_REAR, ADR_REAR_DEC,
        ADR_SLOT_I, ADR_SLOT_IM1, ADR_SLOT_POS
    } t_adr;
    // Memory write data source.
    typedef enum logic {DAT_WORD, DAT_RDATA} t_dat;
    // Update of an index or of the fill count.
    typedef enum logic [1:0] {UPD_HOLD, UPD_INC, UPD_DEC} t_upd;
    // Update of the shift counter.
    typedef enum logic [1:0] {I_HOLD, I_LOAD_COUNT, I_DEC} t_iop;
    // Result issued by a step.
    typedef enum logic [1:0] {EMIT_NONE, EMIT_OK_ZERO, EMIT_OK_RDATA} t_emit;

    // One control word of the program.
    typedef struct packed {
        t_chk  chk;
        t_jmp  jmp;
        t_step target;
        t_mem  mem;
        t_adr  adr;
        t_dat  dat;
        t_upd  front_op;
        t_upd  rear_op;
        t_upd  cnt_op;
        t_iop  iop;
        t_emit emit;
    } t_ctrl;

    localparam t_ctrl CW_NOP = '{
        chk: CHK_NONE, jmp: JMP_IDLE, target: STEP_IDLE, mem: MEM_NONE,
        adr: ADR_FRONT, dat: DAT_WORD, front_op: UPD_HOLD, rear_op: UPD_HOLD,
        cnt_op: UPD_HOLD, iop: I_HOLD, emit: EMIT_NONE
    };

    // The microcode program, one control word per step.
    function automatic t_ctrl f_ucode(input t_step step);
        t_ctrl c;
        c = CW_NOP;
        case (step)
            STEP_PUSHF: begin
                c.chk      = CHK_FULL;
                c.mem      = MEM_WRITE;
                c.adr      = ADR_FRONT_DEC;
                c.front_op = UPD_DEC;
                c.cnt_op   = UPD_INC;
                c.emit     = EMIT_OK_ZERO;
            end
            STEP_PUSHB: begin
                c.chk     = CHK_FULL;
                c.mem     = MEM_WRITE;
                c.adr     = ADR_REAR;
                c.rear_op = UPD_INC;
                c.cnt_op  = UPD_INC;
                c.emit    = EMIT_OK_ZERO;
            end
            STEP_POPF_RD: begin
                c.chk = CHK_EMPTY;
                c.jmp = JMP_NEXT;
                c.mem = MEM_READ;
                c.adr = ADR_FRONT;
            end
            STEP_POPF_EM: begin
                c.front_op = UPD_INC;
                c.cnt_op   = UPD_DEC;
                c.emit     = EMIT_OK_RDATA;
            end
            STEP_POPB_RD: begin
                c.chk = CHK_EMPTY;
                c.jmp = JMP_NEXT;
                c.mem = MEM_READ;
                c.adr = ADR_REAR_DEC;
            end
            STEP_POPB_EM: begin
                c.rear_op = UPD_DEC;
                c.cnt_op  = UPD_DEC;
                c.emit    = EMIT_OK_RDATA;
            end
            STEP_PEEKF_RD: begin
                c.chk    = CHK_EMPTY;
                c.jmp    = JMP_TARGET;
                c.target = STEP_PEEK_EM;
                c.mem    = MEM_READ;
                c.adr    = ADR_FRONT;
            end
            STEP_PEEKB_RD: begin
                c.chk = CHK_EMPTY;
                c.jmp = JMP_NEXT;
                c.mem = MEM_READ;
                c.adr = ADR_REAR_DEC;
            end
            STEP_PEEK_EM: begin
                c.emit = EMIT_OK_RDATA;
            end
            STEP_INS_CHK: begin
                c.chk = CHK_INSERT;
                c.jmp = JMP_NEXT;
                c.iop = I_LOAD_COUNT;
            end
            STEP_INS_LOOP: begin
                c.jmp    = JMP_IF_DONE;
                c.target = STEP_INS_PUT;
                c.mem    = MEM_READ;
                c.adr    = ADR_SLOT_IM1;
            end
            STEP_INS_MOVE: begin
                c.jmp    = JMP_TARGET;
                c.target = STEP_INS_LOOP;
                c.mem    = MEM_WRITE;
                c.adr    = ADR_SLOT_I;
                c.dat    = DAT_RDATA;
                c.iop    = I_DEC;
            end
            STEP_INS_PUT: begin
                c.mem     = MEM_WRITE;
                c.adr     = ADR_SLOT_POS;
                c.rear_op = UPD_INC;
                c.cnt_op  = UPD_INC;
                c.emit    = EMIT_OK_ZERO;
            end
            STEP_NOP: begin
                c.emit = EMIT_OK_ZERO;
            end
            default: begin
                c = CW_NOP;
            end
        endcase
        return c;
    endfunction

    // First step of each action.
    function automatic t_step f_entry(input logic [2:0] action);
        t_step s;
        case (action)
            ACT_PUSH_FRONT: s = STEP_PUSHF;
            ACT_PUSH_BACK:  s = STEP_PUSHB;
            ACT_POP_FRONT:  s = STEP_POPF_RD;
            ACT_POP_BACK:   s = STEP_POPB_RD;
            ACT_PEEK_FRONT: s = STEP_PEEKF_RD;
            ACT_PEEK_BACK:  s = STEP_PEEKB_RD;
            ACT_INSERT:     s = STEP_INS_CHK;
            default:        s = STEP_NOP;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ring_buffer_deque_core.sv @@
// Top level of the ring buffer deque: microcoded sequencer and datapath.
// Depends on rbd_pkg and rbd_ram.
//
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             i_action, i_value_in, i_position
// result    out        o_done, one cycle         o_value_out, o_status, o_fill_count
//
// A request is taken at a rising edge with start high and busy low; the result
// is on the ports for one cycle with o_done high, and busy is low in that cycle.
// Insert moves the entries from position p to the rear up one slot, each by a
// read and a write through the single memory port, then writes the word at p.
// Failing checks end the request after its first step. Reset is synchronous
// and needs no clearing pass; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_deque_core #(
    parameter int DEPTH = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic        [2:0]            i_action,
    input  wire logic signed [31:0]           i_value_in,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_position,
    output logic                              o_done,
    output logic signed [31:0]                o_value_out,
    output logic        [1:0]                 o_status,
    output logic [$clog2(DEPTH+1)-1:0]        o_fill_count
);
    import rbd_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    // Circular index arithmetic.
    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] f_dec(input logic [IW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + SW'(off);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[IW-1:0];
    endfunction

    // Sequencer and datapath registers.
    t_step         r_pc, n_pc;
    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_rear, n_rear;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    logic [31:0]   r_word;
    logic [CW-1:0] r_pos;
    logic          r_done, n_done;
    logic [31:0]   r_value, n_value;
    logic [1:0]    r_status, n_status;
    logic [CW-1:0] r_fill;

    t_ctrl         c;
    logic          fail;
    logic [1:0]    fail_status;
    logic          accept;
    logic          mem_we;
    logic          mem_re;
    logic [IW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    assign busy   = (r_pc != STEP_IDLE);
    assign accept = start && !busy;
    assign c      = f_ucode(r_pc);

    // Precondition check of the current step.
    always_comb begin
        fail        = 1'b0;
        fail_status = ST_OK;
        case (c.chk)
            CHK_FULL: begin
                fail        = (r_count == FULL_CNT);
                fail_status = ST_FULL;
            end
            CHK_EMPTY: begin
                fail        = (r_count == '0);
                fail_status = ST_EMPTY;
            end
            CHK_INSERT: begin
                if (r_pos > r_count) begin
                    fail        = 1'b1;
                    fail_status = ST_BADPOS;
                end else if (r_count == FULL_CNT) begin
                    fail        = 1'b1;
                    fail_status = ST_FULL;
                end
            end
            default: begin
                fail = 1'b0;
            end
        endcase
    end

    // Memory address selection.
    always_comb begin
        case (c.adr)
            ADR_FRONT:     mem_addr = r_front;
            ADR_FRONT_DEC: mem_addr = f_dec(r_front);
            ADR_REAR:      mem_addr = r_rear;
            ADR_REAR_DEC:  mem_addr = f_dec(r_rear);
            ADR_SLOT_I:    mem_addr = f_slot(r_front, r_i);
            ADR_SLOT_IM1:  mem_addr = f_slot(r_front, r_i - 1'b1);
            ADR_SLOT_POS:  mem_addr = f_slot(r_front, r_pos);
            default:       mem_addr = r_front;
        endcase
    end

    assign mem_we    = (c.mem == MEM_WRITE) && !fail;
    assign mem_re    = (c.mem == MEM_READ) && !fail;
    assign mem_wdata = (c.dat == DAT_RDATA) ? mem_rdata : r_word;

    // Index, count and shift counter updates; a failed check changes nothing.
    always_comb begin
        n_front = r_front;
        n_rear  = r_rear;
        n_count = r_count;
        n_i     = r_i;
        if (!fail) begin
            case (c.front_op)
                UPD_INC: n_front = f_inc(r_front);
                UPD_DEC: n_front = f_dec(r_front);
                default: n_front = r_front;
            endcase
            case (c.rear_op)
                UPD_INC: n_rear = f_inc(r_rear);
                UPD_DEC: n_rear = f_dec(r_rear);
                default: n_rear = r_rear;
            endcase
            case (c.cnt_op)
                UPD_INC: n_count = r_count + 1'b1;
                UPD_DEC: n_count = r_count - 1'b1;
                default: n_count = r_count;
            endcase
            case (c.iop)
                I_LOAD_COUNT: n_i = r_count;
                I_DEC:        n_i = r_i - 1'b1;
                default:      n_i = r_i;
            endcase
        end
    end

    // Next step: dispatch on a new request, else follow the control word.
    always_comb begin
        if (accept) begin
            n_pc = f_entry(i_action);
        end else if (fail) begin
            n_pc = STEP_IDLE;
        end else begin
            case (c.jmp)
                JMP_NEXT:    n_pc = r_pc + 1'b1;
                JMP_TARGET:  n_pc = c.target;
                JMP_IF_DONE: n_pc = (r_i == r_pos) ? c.target : r_pc + 1'b1;
                default:     n_pc = STEP_IDLE;
            endcase
        end
    end

    // Result of the current step.
    always_comb begin
        n_done   = fail || (c.emit != EMIT_NONE);
        n_value  = (!fail && c.emit == EMIT_OK_RDATA) ? mem_rdata : '0;
        n_status = fail ? fail_status : ST_OK;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= STEP_IDLE;
            r_front <= '0;
            r_rear  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_front <= n_front;
            r_rear  <= n_rear;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_value_in;
            r_pos  <= i_position;
        end
        r_i      <= n_i;
        r_value  <= n_value;
        r_status <= n_status;
        r_fill   <= n_count;
    end

    rbd_ram #(
        .DEPTH (DEPTH),
        .AW    (IW),
        .DW    (32)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_done       = r_done;
    assign o_value_out  = r_value;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;

endmodule

`default_nettype wire

@@ rtl/rbd_ram.sv @@
// Single-port entry memory of the ring buffer deque with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rbd_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write and read share the one address port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ tb/ring_buffer_deque_checker.sv @@
// Checker for the ring buffer deque: watches the request and result channels,
// predicts each result from its own deque state and compares field by field.
// Depends on rbd_pkg for the action and status codes.
`timescale 1ns / 1ps

module ring_buffer_deque_checker #(
    parameter int DEPTH = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic                         i_busy,
    input  wire logic        [2:0]            i_action,
    input  wire logic signed [31:0]           i_value_in,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_position,
    input  wire logic                         i_done,
    input  wire logic signed [31:0]           i_value_out,
    input  wire logic        [1:0]            i_status,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_fill_count,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked
);
    import rbd_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef struct packed {
        logic signed [31:0] value;
        logic        [1:0]  status;
        logic [PW-1:0]      fill;
    } t_deque_result;

    // Shadow copy of the deque.
    logic signed [31:0] slots [DEPTH];
    logic [IW-1:0]      head;
    logic [IW-1:0]      tail;
    logic [PW-1:0]      held;

    t_deque_result      outstanding [$];
    t_deque_result      want;
    t_deque_result      fresh;
    int                 err_count;
    int                 checked;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        return IW'((int'(idx) + 1) % DEPTH);
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
        return IW'((int'(idx) + DEPTH - 1) % DEPTH);
    endfunction

    // Physical slot of the entry at a given offset from the front.
    function automatic logic [IW-1:0] slot_at(input int offset);
        return IW'((int'(head) + offset) % DEPTH);
    endfunction

    // Applies one request to the shadow deque and returns what it should report.
    task automatic apply_request(
        input  logic [2:0]         act,
        input  logic signed [31:0] word,
        input  logic [PW-1:0]      pos,
        output t_deque_result      res
    );
        int k;
        res.value  = '0;
        res.status = ST_OK;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (act == ACT_PUSH_FRONT) begin
                    head        = ring_prev(head);
                    slots[head] = word;
                    held        = held + 1'b1;
                end else begin
                    slots[tail] = word;
                    tail        = ring_next(tail);
                    held        = held + 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else if (act == ACT_POP_FRONT) begin
                    res.value = slots[head];
                    head      = ring_next(head);
                    held      = held - 1'b1;
                end else if (act == ACT_POP_BACK) begin
                    tail      = ring_prev(tail);
                    res.value = slots[tail];
                    held      = held - 1'b1;
                end else if (act == ACT_PEEK_FRONT) begin
                    res.value = slots[head];
                end else begin
                    res.value = slots[ring_prev(tail)];
                end
            end
            ACT_INSERT: begin
                // The position check wins over the full check.
                if (pos > held) begin
                    res.status = ST_BADPOS;
                end else if (held >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (k = int'(held); k > int'(pos); k--) begin
                        slots[slot_at(k)] = slots[slot_at(k - 1)];
                    end
                    slots[slot_at(int'(pos))] = word;
                    tail = ring_next(tail);
                    held = held + 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.fill = held;
    endtask

    // A result is compared before the request of the same edge is predicted,
    // since it always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head = '0;
            tail = '0;
            held = '0;
            outstanding.delete();
            err_count = 0;
            checked   = 0;
        end else begin
            if (i_done) begin
                if (outstanding.size() == 0) begin
                    $display("%0t: result with no request outstanding: %s %0d %0d %0d",
                             $time, "value_out status fill", i_value_out, i_status,
                             i_fill_count);
                    err_count++;
                end else begin
                    want = outstanding.pop_front();
                    checked++;
                    if (i_value_out !== want.value) begin
                        $display("%0t: value_out mismatch: expected %0d, actual %0d",
                                 $time, want.value, i_value_out);
                        err_count++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_status);
                        err_count++;
                    end
                    if (i_fill_count !== want.fill) begin
                        $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                                 $time, want.fill, i_fill_count);
                        err_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_request(i_action, i_value_in, i_position, fresh);
                outstanding.push_back(fresh);
            end
        end
        o_errors  <= err_count;
        o_pending <= outstanding.size();
        o_checked <= checked;
    end

endmodule

@@ tb/tb_ring_buffer_deque.sv @@
// Testbench top for the ring buffer deque: drives directed and random requests
// through three idle phases and gives the verdict.
// Depends on rbd_pkg, ring_buffer_deque_core and ring_buffer_deque_checker.
`timescale 1ns / 1ps

module tb_ring_buffer_deque_core;
    import rbd_pkg::*;

    localparam int DEPTH       = 8;
    localparam int PW          = $clog2(DEPTH + 1);
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 24;
    localparam int PHASE_ITEMS = 245;

    // Code seven has no action behind it.
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic        [2:0]    i_action;
    logic signed [31:0]   i_value_in;
    logic [PW-1:0]        i_position;
    logic                 o_done;
    logic signed [31:0]   o_value_out;
    logic        [1:0]    o_status;
    logic [PW-1:0]        o_fill_count;

    int errors;
    int pending;
    int checked;
    int idle_pct;
    int stall_cycles;
    int sent_by_action [8];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ring_buffer_deque_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_value_in  (i_value_in),
        .i_position  (i_position),
        .o_done      (o_done),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_fill_count(o_fill_count)
    );

    ring_buffer_deque_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_action    (i_action),
        .i_value_in  (i_value_in),
        .i_position  (i_position),
        .i_done      (o_done),
        .i_value_out (o_value_out),
        .i_status    (o_status),
        .i_fill_count(o_fill_count),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without progress", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Words with a bias towards the extremes and simple patterns.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Action mix that either fills the deque or drains it.
    function automatic logic [2:0] pick_action(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return ACT_UNUSED;
        if (filling) begin
            if (r < 30) return ACT_PUSH_FRONT;
            if (r < 58) return ACT_PUSH_BACK;
            if (r < 78) return ACT_INSERT;
            if (r < 84) return ACT_POP_FRONT;
            if (r < 90) return ACT_POP_BACK;
            if (r < 95) return ACT_PEEK_FRONT;
            return ACT_PEEK_BACK;
        end
        if (r < 10) return ACT_PUSH_FRONT;
        if (r < 18) return ACT_PUSH_BACK;
        if (r < 25) return ACT_INSERT;
        if (r < 50) return ACT_POP_FRONT;
        if (r < 75) return ACT_POP_BACK;
        if (r < 87) return ACT_PEEK_FRONT;
        return ACT_PEEK_BACK;
    endfunction

    // Issues one request after a random idle stretch; called at a falling edge
    // and returns at the falling edge after the request was taken.
    task automatic send_request(
        input logic [2:0]         act,
        input logic signed [31:0] word,
        input logic [PW-1:0]      pos
    );
        while ($urandom_range(99) < idle_pct) begin
            start      = 1'b0;
            i_action   = 3'($urandom);
            i_value_in = $urandom;
            i_position = PW'($urandom_range(DEPTH));
            @(negedge i_clk);
        end
        start      = 1'b1;
        i_action   = act;
        i_value_in = word;
        i_position = pos;
        // Busy only moves at a rising edge, so its level here holds until the next one.
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        sent_by_action[act]++;
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic wait_for_results();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic run_random(input int count);
        bit filling;
        int run_left;
        filling  = 1'b1;
        run_left = 0;
        repeat (count) begin
            if (run_left == 0) begin
                filling  = ~filling;
                run_left = $urandom_range(8, 24);
            end
            run_left--;
            send_request(pick_action(filling), pick_word(), PW'($urandom_range(DEPTH)));
            if ($urandom_range(99) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_action   = ACT_PUSH_FRONT;
        i_value_in = '0;
        i_position = '0;
        idle_pct   = 13;
        foreach (sent_by_action[a]) sent_by_action[a] = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty deque errors, insert checks, fill to full, full errors.
        send_request(ACT_POP_FRONT, 32'sd5, '0);
        send_request(ACT_POP_BACK, 32'sd5, '0);
        send_request(ACT_PEEK_FRONT, 32'sd5, '0);
        send_request(ACT_PEEK_BACK, 32'sd5, '0);
        send_request(ACT_INSERT, 32'sd9, PW'(1));
        send_request(ACT_INSERT, 32'sh8000_0000, PW'(0));
        send_request(ACT_UNUSED, -32'sd1, PW'(DEPTH));
        send_request(ACT_PUSH_BACK, 32'sh7FFF_FFFF, '0);
        send_request(ACT_PUSH_FRONT, -32'sd1, '0);
        send_request(ACT_PUSH_BACK, 32'sd0, '0);
        send_request(ACT_INSERT, 32'sh1234_5678, PW'(4));
        send_request(ACT_INSERT, 32'sh0F0F_0F0F, PW'(1));
        send_request(ACT_PUSH_FRONT, 32'sh5555_5555, '0);
        send_request(ACT_PUSH_BACK, 32'shAAAA_AAAA, '0);
        send_request(ACT_PUSH_FRONT, 32'sd1, '0);
        send_request(ACT_PUSH_BACK, 32'sd2, '0);
        send_request(ACT_INSERT, 32'sd3, PW'(DEPTH));
        send_request(ACT_PEEK_FRONT, '0, '0);
        send_request(ACT_PEEK_BACK, '0, '0);
        send_request(ACT_POP_FRONT, '0, '0);
        send_request(ACT_POP_BACK, '0, '0);
        send_request(ACT_INSERT, 32'sd4, PW'(DEPTH - 1));
        send_request(ACT_INSERT, 32'sd6, PW'(0));
        wait_for_results();

        // Random: light sender idling, then heavy, then none.
        run_random(PHASE_ITEMS);
        idle_pct = 86;
        run_random(PHASE_ITEMS);
        idle_pct = 0;
        run_random(PHASE_ITEMS);

        // Let any stray result show up before the verdict.
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Summary: %0d pushes, %0d pops, %0d peeks, %0d inserts, %0d unused codes",
                 sent_by_action[ACT_PUSH_FRONT] + sent_by_action[ACT_PUSH_BACK],
                 sent_by_action[ACT_POP_FRONT] + sent_by_action[ACT_POP_BACK],
                 sent_by_action[ACT_PEEK_FRONT] + sent_by_action[ACT_PEEK_BACK],
                 sent_by_action[ACT_INSERT], sent_by_action[ACT_UNUSED]);
        $display("Summary: %0d results checked over three idle phases, %0d mismatches",
                 checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
